// ----- rtl/core/wsft_pkg.sv -----
// Shared types, constants and helper functions for the weather sensor frame transmitter.
// Used by the frame builder, the tick sequencer and the top level. No dependencies.
package wsft_pkg;

  // Field and register widths.
  localparam int unsigned HOUSE_W   = 4;
  localparam int unsigned CHANNEL_W = 3;
  localparam int unsigned REPEAT_W  = 4;
  localparam int unsigned TICKS_W   = 14;
  localparam int unsigned COUNT_W   = 15;
  localparam int unsigned HUM_W     = 7;
  localparam int unsigned TEMP_W    = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned FRAME_LEN = 36;
  localparam int unsigned POS_W     = 6;

  // Fixed parts of the frame and the temperature offset.
  localparam logic [3:0]        FRAME_PREAMBLE = 4'b1100;
  localparam logic [2:0]        FRAME_MARKER   = 3'b110;
  localparam logic [TEMP_W-1:0] TEMP_OFFSET    = 16'd6400;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_HOUSE_CODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_NUMBER = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_TICKS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS  = 3'd5;

  // Register values after reset.
  localparam logic [HOUSE_W-1:0]   RST_HOUSE_CODE     = 4'd1;
  localparam logic [CHANNEL_W-1:0] RST_CHANNEL_NUMBER = 3'd1;
  localparam logic [REPEAT_W-1:0]  RST_REPEAT_COUNT   = 4'd3;
  localparam logic [TICKS_W-1:0]   RST_SHORT_TICKS    = 14'd1000;
  localparam logic [TICKS_W-1:0]   RST_LONG_TICKS     = 14'd2000;
  localparam logic [TICKS_W-1:0]   RST_TRIGGER_TICKS  = 14'd8000;

  // Settings that go into the frame and are latched with each request.
  typedef struct packed {
    logic [HOUSE_W-1:0]   house_code;
    logic [CHANNEL_W-1:0] channel_number;
    logic [REPEAT_W-1:0]  repeat_count;
  } frame_cfg_t;

  // Pulse timing, read whenever a segment starts.
  typedef struct packed {
    logic [TICKS_W-1:0] short_ticks;
    logic [TICKS_W-1:0] long_ticks;
    logic [TICKS_W-1:0] trigger_ticks;
  } timing_cfg_t;

  // One tick's result.
  typedef struct packed {
    logic tx_level;
    logic busy_res;
    logic request_taken;
    logic sequence_done;
  } tick_result_t;

  // A segment that works out to zero ticks still lasts one tick.
  function automatic logic [COUNT_W-1:0] seg_len(input logic [COUNT_W-1:0] n);
    return (n == '0) ? COUNT_W'(1) : n;
  endfunction

  // Frame bit at a transmit position, most significant bit first; zero past the end.
  function automatic logic bit_at(input logic [FRAME_LEN-1:0] f,
                                  input logic [POS_W-1:0] pos);
    logic [POS_W-1:0] idx;
    idx = POS_W'(FRAME_LEN - 1) - pos;
    return (pos < POS_W'(FRAME_LEN)) ? f[idx] : 1'b0;
  endfunction

endpackage

// ----- rtl/core/weather_sensor_frame_transmitter_core.sv -----
// Weather sensor frame transmitter top level: configuration registers, handshake, result register.
// Depends on wsft_pkg, wsft_frame and wsft_seq.
// Timing: the result of a tick is registered and offered in the cycle after its input transfer.
// Throughput: one tick per clock; a new tick is taken in the cycle that the previous result
// transfers, and a stalled result holds the input back.
// Reset: synchronous and active high; the transmitter goes idle and the registers take their defaults.
module weather_sensor_frame_transmitter_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic [6:0]         humidity,
  input  logic signed [15:0] temperature_q7,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               tx_level,
  output logic               busy_res,
  output logic               request_taken,
  output logic               sequence_done,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [13:0]        cfg_data
);
  import wsft_pkg::*;

  frame_cfg_t           frame_cfg;
  timing_cfg_t          timing_cfg;
  logic [FRAME_LEN-1:0] new_frame;
  tick_result_t         result;
  logic                 in_xfer;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_cfg.house_code     <= RST_HOUSE_CODE;
      frame_cfg.channel_number <= RST_CHANNEL_NUMBER;
      frame_cfg.repeat_count   <= RST_REPEAT_COUNT;
      timing_cfg.short_ticks   <= RST_SHORT_TICKS;
      timing_cfg.long_ticks    <= RST_LONG_TICKS;
      timing_cfg.trigger_ticks <= RST_TRIGGER_TICKS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HOUSE_CODE:     frame_cfg.house_code     <= cfg_data[HOUSE_W-1:0];
        REG_CHANNEL_NUMBER: frame_cfg.channel_number <= cfg_data[CHANNEL_W-1:0];
        REG_REPEAT_COUNT:   frame_cfg.repeat_count   <= cfg_data[REPEAT_W-1:0];
        REG_SHORT_TICKS:    timing_cfg.short_ticks   <= cfg_data;
        REG_LONG_TICKS:     timing_cfg.long_ticks    <= cfg_data;
        REG_TRIGGER_TICKS:  timing_cfg.trigger_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // A tick is taken unless a waiting result is being held back.
  assign in_stall = out_valid & out_stall;
  assign in_xfer  = in_valid & ~in_stall;

  wsft_frame u_frame (
    .cfg            (frame_cfg),
    .humidity       (humidity),
    .temperature_q7 (temperature_q7),
    .frame          (new_frame)
  );

  wsft_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .tick       (in_xfer),
    .cmd        (cmd),
    .new_frame  (new_frame),
    .frame_cfg  (frame_cfg),
    .timing_cfg (timing_cfg),
    .result     (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      tx_level      <= result.tx_level;
      busy_res      <= result.busy_res;
      request_taken <= result.request_taken;
      sequence_done <= result.sequence_done;
    end
  end

endmodule

// ----- rtl/core/wsft_frame.sv -----
// Frame builder: assembles the 36-bit frame with its even parity bit from one reading.
// Depends on wsft_pkg.
module wsft_frame (
  input  wsft_pkg::frame_cfg_t               cfg,
  input  logic [6:0]                         humidity,
  input  logic signed [15:0]                 temperature_q7,
  output logic [wsft_pkg::FRAME_LEN-1:0]     frame
);
  import wsft_pkg::*;

  logic [TEMP_W-1:0]    temp_sum;
  logic [1:0]           channel_code;
  logic [FRAME_LEN-2:0] payload;

  // Offset the temperature so that it is sent as an unsigned 15-bit value.
  assign temp_sum     = TEMP_W'(unsigned'(temperature_q7)) + TEMP_OFFSET;
  assign channel_code = 2'(cfg.channel_number - CHANNEL_W'(1));

  assign payload = {FRAME_PREAMBLE, cfg.house_code, channel_code, FRAME_MARKER,
                    humidity, temp_sum[COUNT_W-1:0]};

  // The parity bit makes the count of ones in the whole frame even.
  assign frame = {payload, ^payload};

endmodule

// ----- rtl/core/wsft_seq.sv -----
// Tick sequencer: holds the transmit state and works out one tick per accepted item.
// Depends on wsft_pkg; takes a freshly built frame from wsft_frame.
module wsft_seq (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            tick,
  input  logic                            cmd,
  input  logic [wsft_pkg::FRAME_LEN-1:0]  new_frame,
  input  wsft_pkg::frame_cfg_t            frame_cfg,
  input  wsft_pkg::timing_cfg_t           timing_cfg,
  output wsft_pkg::tick_result_t          result
);
  import wsft_pkg::*;

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_START    = 3'd1;
  localparam logic [2:0] PH_BIT_A    = 3'd2;
  localparam logic [2:0] PH_BIT_B    = 3'd3;
  localparam logic [2:0] PH_END_HIGH = 3'd4;
  localparam logic [2:0] PH_END_LOW  = 3'd5;

  // State registers.
  logic [FRAME_LEN-1:0] frame_bits,    frame_bits_next;
  logic [POS_W-1:0]     bit_position,  bit_position_next;
  logic [2:0]           segment_phase, segment_phase_next;
  logic [COUNT_W-1:0]   tick_counter,  tick_counter_next;
  logic [REPEAT_W-1:0]  repeats_left,  repeats_left_next;
  logic                 next_level,    next_level_next;
  logic                 busy_flag,     busy_flag_next;

  // State after a possible request has been taken.
  logic [FRAME_LEN-1:0] frame_a;
  logic [POS_W-1:0]     pos_a;
  logic [2:0]           phase_a;
  logic [COUNT_W-1:0]   count_a;
  logic [REPEAT_W-1:0]  reps_a;
  logic                 level_a;
  logic                 busy_a;

  logic [COUNT_W-1:0]   start_len, short_len, long_len, half_len;
  logic [POS_W-1:0]     pos_adv;
  logic                 cur_bit, adv_bit, adv_end, end_level, do_adv;
  logic                 level, taken, done;

  // Segment lengths from the current timing settings.
  assign start_len = seg_len({timing_cfg.trigger_ticks, 1'b0});
  assign short_len = seg_len({1'b0, timing_cfg.short_ticks});
  assign long_len  = seg_len({1'b0, timing_cfg.long_ticks});
  assign half_len  = seg_len({2'b00, timing_cfg.short_ticks[TICKS_W-1:1]});

  // Bits at the current and the following transmit positions.
  assign cur_bit = bit_at(frame_a, pos_a);
  assign pos_adv = pos_a + POS_W'(1);
  assign adv_bit = bit_at(frame_a, pos_adv);
  assign adv_end = (pos_adv >= POS_W'(FRAME_LEN));

  // A zero bit toggles the level before the next bit or the frame end is chosen.
  assign end_level = (phase_a == PH_BIT_A) ? ~level_a : level_a;

  // Take a start request, then run the segment timer for this tick.
  always_comb begin
    frame_a = frame_bits;
    pos_a   = bit_position;
    phase_a = segment_phase;
    count_a = tick_counter;
    reps_a  = repeats_left;
    level_a = next_level;
    busy_a  = busy_flag;
    taken   = 1'b0;
    done    = 1'b0;
    if (cmd && !busy_flag) begin
      taken   = 1'b1;
      frame_a = new_frame;
      reps_a  = frame_cfg.repeat_count;
      if (frame_cfg.repeat_count == '0) begin
        done = 1'b1;
      end else begin
        busy_a  = 1'b1;
        phase_a = PH_START;
        count_a = start_len;
        level_a = 1'b1;
        pos_a   = '0;
      end
    end

    frame_bits_next    = frame_a;
    bit_position_next  = pos_a;
    segment_phase_next = phase_a;
    tick_counter_next  = count_a;
    repeats_left_next  = reps_a;
    next_level_next    = level_a;
    busy_flag_next     = busy_a;
    level              = 1'b0;
    do_adv             = 1'b0;

    if (busy_a) begin
      case (phase_a)
        PH_BIT_A:    level = level_a;
        PH_BIT_B:    level = ~level_a;
        PH_END_HIGH: level = 1'b1;
        default:     level = 1'b0;
      endcase

      if (count_a != '0) begin
        tick_counter_next = count_a - COUNT_W'(1);
      end

      if (tick_counter_next == '0) begin
        unique case (phase_a)
          PH_START: begin
            segment_phase_next = PH_BIT_A;
            tick_counter_next  = cur_bit ? short_len : long_len;
          end
          PH_BIT_A: begin
            if (cur_bit) begin
              segment_phase_next = PH_BIT_B;
              tick_counter_next  = short_len;
            end else begin
              next_level_next = ~level_a;
              do_adv          = 1'b1;
            end
          end
          PH_BIT_B: begin
            do_adv = 1'b1;
          end
          PH_END_HIGH: begin
            segment_phase_next = PH_END_LOW;
            tick_counter_next  = start_len;
          end
          default: begin
            repeats_left_next = reps_a - REPEAT_W'(1);
            if (repeats_left_next == '0) begin
              done               = 1'b1;
              busy_flag_next     = 1'b0;
              segment_phase_next = PH_IDLE;
            end else begin
              segment_phase_next = PH_START;
              tick_counter_next  = start_len;
              next_level_next    = 1'b1;
              bit_position_next  = '0;
            end
          end
        endcase

        // Move to the next bit, or close the frame after the last one.
        if (do_adv) begin
          bit_position_next = pos_adv;
          if (adv_end) begin
            if (end_level) begin
              segment_phase_next = PH_END_HIGH;
              tick_counter_next  = half_len;
            end else begin
              segment_phase_next = PH_END_LOW;
              tick_counter_next  = start_len;
            end
          end else begin
            segment_phase_next = PH_BIT_A;
            tick_counter_next  = adv_bit ? short_len : long_len;
          end
        end
      end
    end
  end

  assign result = '{tx_level: level, busy_res: busy_a, request_taken: taken,
                    sequence_done: done};

  // State advances by one tick per transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_bits    <= '0;
      bit_position  <= '0;
      segment_phase <= PH_IDLE;
      tick_counter  <= '0;
      repeats_left  <= '0;
      next_level    <= 1'b1;
      busy_flag     <= 1'b0;
    end else if (tick) begin
      frame_bits    <= frame_bits_next;
      bit_position  <= bit_position_next;
      segment_phase <= segment_phase_next;
      tick_counter  <= tick_counter_next;
      repeats_left  <= repeats_left_next;
      next_level    <= next_level_next;
      busy_flag     <= busy_flag_next;
    end
  end

endmodule

// ----- rtl/core/wsft_chk.sv -----
// Port-level checker for the weather sensor frame transmitter, bound to the top level.
// Depends only on the ports of weather_sensor_frame_transmitter_core.
module wsft_chk (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic tx_level,
  input logic busy_res,
  input logic request_taken,
  input logic sequence_done
);

  // Every input transfer yields a result in the following cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("no result after an input transfer");

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(tx_level) && $stable(busy_res)
      && $stable(request_taken) && $stable(sequence_done))
    else $error("stalled result changed");

  // The pin stays low while idle.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !busy_res |-> !tx_level)
    else $error("pin high while idle");

  // A sequence ends either in a busy tick or with a request that sends nothing.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && sequence_done |-> busy_res || request_taken)
    else $error("sequence end outside a sequence");

  // A taken request either starts a sequence or completes it at once.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && request_taken |-> busy_res || sequence_done)
    else $error("taken request neither started nor finished");

endmodule

bind weather_sensor_frame_transmitter_core wsft_chk u_wsft_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .tx_level      (tx_level),
  .busy_res      (busy_res),
  .request_taken (request_taken),
  .sequence_done (sequence_done)
);
